@@ src/bmp565_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp565_pkg
// Shared types, register indexes and helpers for the BMP pixel to RGB565
// converter.
// ----------------------------------------------------------------------------
package bmp565_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIXEL_W = 32;
	localparam int MASK_W  = 16;
	localparam int DIM_REG_W = 11;
	localparam int INDEX_W = 20;
	localparam int COLOR_W = 16;
	localparam int ALPHA_W = 8;
	localparam int REG_INDEX_W = 3;

	localparam logic [MASK_W-1:0] RED_MASK_RST   = 16'h7C00;
	localparam logic [MASK_W-1:0] GREEN_MASK_RST = 16'h03E0;
	localparam logic [MASK_W-1:0] BLUE_MASK_RST  = 16'h001F;
	localparam logic [3:0] BLUE_POS = 4'd11;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_PIXEL_MODE   = 3'd0,
		REG_RED_MASK     = 3'd1,
		REG_GREEN_MASK   = 3'd2,
		REG_BLUE_MASK    = 3'd3,
		REG_IMAGE_WIDTH  = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5
	} reg_index_t;

	typedef enum logic {
		MODE_MASKED16 = 1'b0,
		MODE_BGRA32   = 1'b1
	} pixel_mode_t;

	typedef struct packed {
		pixel_mode_t            pixel_mode;
		logic [MASK_W-1:0]      red_mask;
		logic [MASK_W-1:0]      green_mask;
		logic [MASK_W-1:0]      blue_mask;
		logic [DIM_REG_W-1:0]   image_width;
		logic [DIM_REG_W-1:0]   image_height;
	} cfg_t;

	// Position of the lowest set bit; 16 for an empty mask, which shifts
	// every bit out and so yields a zero field.
	function automatic logic [4:0] low_bit_pos(input logic [MASK_W-1:0] m);
		logic [4:0] pos;
		pos = 5'd16;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

@@ src/bmp565_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp565_cfg_regs
// Configuration register file. A geometry write also restarts the image.
// ----------------------------------------------------------------------------
module bmp565_cfg_regs
	import bmp565_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output      logic                    cfg_ready,
	input  wire logic [REG_INDEX_W-1:0]  cfg_index,
	input  wire logic [31:0]             cfg_data,
	output      cfg_t                    cfg,
	output      logic                    geometry_write
);

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	always_comb begin
		geometry_write = 1'b0;
		if (wr_en && (reg_index_t'(cfg_index) == REG_IMAGE_WIDTH ||
				reg_index_t'(cfg_index) == REG_IMAGE_HEIGHT)) begin
			geometry_write = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode   <= MODE_MASKED16;
			cfg_q.red_mask     <= RED_MASK_RST;
			cfg_q.green_mask   <= GREEN_MASK_RST;
			cfg_q.blue_mask    <= BLUE_MASK_RST;
			cfg_q.image_width  <= DIM_REG_W'(1);
			cfg_q.image_height <= DIM_REG_W'(1);
		end else if (wr_en) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:   cfg_q.pixel_mode   <= pixel_mode_t'(cfg_data[0]);
				REG_RED_MASK:     cfg_q.red_mask     <= cfg_data[MASK_W-1:0];
				REG_GREEN_MASK:   cfg_q.green_mask   <= cfg_data[MASK_W-1:0];
				REG_BLUE_MASK:    cfg_q.blue_mask    <= cfg_data[MASK_W-1:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_REG_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/bmp565_position.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp565_position
// Column and row counters of the incoming bottom-up image, with the clamped
// geometry, the flipped row and the end-of-image flag.
// ----------------------------------------------------------------------------
module bmp565_position
	import bmp565_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1),
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1),
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              clear,
	input  wire logic              advance,
	output      logic [WDIM_W-1:0] width,
	output      logic [COL_W-1:0]  column,
	output      logic [ROW_W-1:0]  flipped_row,
	output      logic              last
);

	localparam int WCMP_W = (WDIM_W > DIM_REG_W) ? WDIM_W : DIM_REG_W;
	localparam int HCMP_W = (HDIM_W > DIM_REG_W) ? HDIM_W : DIM_REG_W;
	localparam logic [WCMP_W-1:0] MAX_W_C = WCMP_W'(MAX_WIDTH);
	localparam logic [HCMP_W-1:0] MAX_H_C = HCMP_W'(MAX_HEIGHT);

	logic [COL_W-1:0]  column_count_q;
	logic [ROW_W-1:0]  row_count_q;
	logic [WCMP_W-1:0] width_ext;
	logic [HCMP_W-1:0] height_ext;
	logic [HDIM_W-1:0] height;
	logic [WDIM_W:0]   column_next;
	logic [HDIM_W:0]   row_next;
	logic              end_row;

	assign width_ext  = WCMP_W'(cfg.image_width);
	assign height_ext = HCMP_W'(cfg.image_height);

	// A zero dimension counts as one, an oversized one as the maximum.
	always_comb begin
		priority if (width_ext == '0) begin
			width = WDIM_W'(1);
		end else if (width_ext > MAX_W_C) begin
			width = WDIM_W'(MAX_WIDTH);
		end else begin
			width = width_ext[WDIM_W-1:0];
		end
		priority if (height_ext == '0) begin
			height = HDIM_W'(1);
		end else if (height_ext > MAX_H_C) begin
			height = HDIM_W'(MAX_HEIGHT);
		end else begin
			height = height_ext[HDIM_W-1:0];
		end
	end

	assign column_next = (WDIM_W + 1)'(column_count_q) + (WDIM_W + 1)'(1);
	assign row_next    = (HDIM_W + 1)'(row_count_q) + (HDIM_W + 1)'(1);
	assign end_row     = column_next >= (WDIM_W + 1)'(width);
	assign last        = end_row && (row_next >= (HDIM_W + 1)'(height));
	assign column      = column_count_q;
	assign flipped_row = ROW_W'(height - HDIM_W'(1) - HDIM_W'(row_count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (clear) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (advance) begin
			if (end_row) begin
				column_count_q <= '0;
				row_count_q    <= last ? '0 : row_next[ROW_W-1:0];
			end else begin
				column_count_q <= column_next[COL_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

@@ src/bmp565_color_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp565_color_conv
// Converts one source pixel to a 16-bit colour with red in the low bits,
// either through the bit-field masks or from B, G, R, A bytes.
// ----------------------------------------------------------------------------
module bmp565_color_conv
	import bmp565_pkg::*;
(
	input  wire cfg_t               cfg,
	input  wire logic [PIXEL_W-1:0] pixel,
	output      logic [COLOR_W-1:0] color,
	output      logic [ALPHA_W-1:0] alpha
);

	logic [MASK_W-1:0] p16;
	logic [4:0]        red_pos;
	logic [4:0]        green_pos;
	logic [4:0]        blue_pos;
	logic [MASK_W-1:0] red_field;
	logic [MASK_W-1:0] green_field;
	logic [MASK_W-1:0] blue_field;
	logic [MASK_W-1:0] green_run;
	logic              green_six;
	logic [COLOR_W-1:0] masked_color;
	logic [COLOR_W-1:0] bgra_color;

	assign p16       = pixel[MASK_W-1:0];
	assign red_pos   = low_bit_pos(cfg.red_mask);
	assign green_pos = low_bit_pos(cfg.green_mask);
	assign blue_pos  = low_bit_pos(cfg.blue_mask);

	assign red_field   = (p16 & cfg.red_mask) >> red_pos;
	assign green_field = (p16 & cfg.green_mask) >> green_pos;
	assign blue_field  = (p16 & cfg.blue_mask) >> blue_pos;

	// The green mask is six bits wide when its run of ones from the lowest
	// set bit stops after exactly six bits.
	assign green_run = cfg.green_mask >> green_pos;
	assign green_six = (green_run[5:0] == 6'h3F) && !green_run[6];

	assign masked_color = red_field
		| (green_six ? (green_field << 5) : (green_field << 6))
		| (blue_field << BLUE_POS);

	assign bgra_color = {pixel[7:3], pixel[15:10], pixel[23:19]};

	always_comb begin
		unique case (cfg.pixel_mode)
			MODE_BGRA32: begin
				color = bgra_color;
				alpha = pixel[31:24];
			end
			default: begin
				color = masked_color;
				alpha = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/bmp_pixel_to_rgb565_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgb565_top
// Converts a stream of BMP pixel words to RGB565 colours with top-down
// frame-buffer positions.
// ----------------------------------------------------------------------------
// Usage: pixel words of a bottom-up image arrive in file order on the input
// channel (in_valid, in_stall, source_pixel), row padding already removed.
// Each item gives one result item on the output channel (out_valid,
// out_stall, pixel_index, color, alpha, last); last marks the final pixel
// of the image, after which the next item starts a new image.
// Each accepted item passes through an input register and a result register
// before out_valid. One item is accepted per clock while in_stall is low; the
// path from the input register to the result register holds the mask
// decode and one multiply-add for the index.
// A stalled result holds in the result register while the input register
// still takes one more item; in_stall rises only when both are full.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always taken and belong in idle periods; writing the width or height
// restarts the image. Reset empties the pipeline, selects 16-bit masked
// mode with 5-5-5 masks and a one-by-one image.
// ----------------------------------------------------------------------------
module bmp_pixel_to_rgb565_top
	import bmp565_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [REG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire logic [PIXEL_W-1:0]     source_pixel,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      logic [INDEX_W-1:0]     pixel_index,
	output      logic [COLOR_W-1:0]     color,
	output      logic [ALPHA_W-1:0]     alpha,
	output      logic                   last
);

	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PROD_W = ROW_W + WDIM_W + 1;
	localparam int SUM_W  = (PROD_W > INDEX_W) ? PROD_W : INDEX_W;

	cfg_t               cfg;
	logic               geometry_write;
	logic [WDIM_W-1:0]  width;
	logic [COL_W-1:0]   column;
	logic [ROW_W-1:0]   flipped_row;
	logic               pos_last;
	logic               accept;
	logic               s2_load;
	logic               s1_free;

	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [COL_W-1:0]   column_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               last_s1;

	logic [COLOR_W-1:0] conv_color;
	logic [ALPHA_W-1:0] conv_alpha;
	logic [SUM_W-1:0]   index_sum;

	logic               valid_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [ALPHA_W-1:0] alpha_s2;
	logic               last_s2;

	bmp565_cfg_regs u_cfg_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cfg            (cfg),
		.geometry_write (geometry_write)
	);

	bmp565_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clear       (geometry_write),
		.advance     (accept),
		.width       (width),
		.column      (column),
		.flipped_row (flipped_row),
		.last        (pos_last)
	);

	bmp565_color_conv u_color_conv (
		.cfg   (cfg),
		.pixel (pixel_s1),
		.color (conv_color),
		.alpha (conv_alpha)
	);

	assign s2_load  = valid_s1 && (!valid_s2 || !out_stall);
	assign s1_free  = !valid_s1 || s2_load;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	assign index_sum = SUM_W'(row_s1) * SUM_W'(width) + SUM_W'(column_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= source_pixel;
			column_s1 <= column;
			row_s1    <= flipped_row;
			last_s1   <= pos_last;
		end
		if (s2_load) begin
			index_s2 <= index_sum[INDEX_W-1:0];
			color_s2 <= conv_color;
			alpha_s2 <= conv_alpha;
			last_s2  <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_index = index_s2;
	assign color       = color_s2;
	assign alpha       = alpha_s2;
	assign last        = last_s2;

endmodule
`default_nettype wire

@@ tb/sv/tb_bmp_pixel_to_rgb565_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_to_rgb565_top
// Self-checking bench for the BMP pixel to RGB565 converter. Pixel words are
// fed through a driver with random gaps, and results are taken by a monitor
// that stalls at random and at set phases for a long stretch. Every result is checked
// field by field against a behavioural converter kept in the bench. A short
// directed part covers the register extremes, then random images follow.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_to_rgb565_top;
	import bmp565_pkg::*;

	localparam int MAX_W          = DEF_MAX_WIDTH;
	localparam int MAX_H          = DEF_MAX_HEIGHT;
	localparam int RANDOM_PIXELS  = 650;
	localparam int SQUEEZE_CYCLES = 80;
	localparam int LIMIT_CYCLES   = 400000;

	typedef struct {
		logic [INDEX_W-1:0] pixel_index;
		logic [COLOR_W-1:0] color;
		logic [ALPHA_W-1:0] alpha;
		logic               last;
	} pixel_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [REG_INDEX_W-1:0] cfg_index = REG_PIXEL_MODE;
	logic [31:0]            cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [PIXEL_W-1:0]     source_pixel = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [INDEX_W-1:0]     pixel_index;
	logic [COLOR_W-1:0]     color;
	logic [ALPHA_W-1:0]     alpha;
	logic                   last;

	bmp_pixel_to_rgb565_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.source_pixel(source_pixel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.color       (color),
		.alpha       (alpha),
		.last        (last)
	);

	// Mirror of the converter's registers and image position.
	pixel_mode_t       conv_mode;
	logic [MASK_W-1:0] conv_red_mask;
	logic [MASK_W-1:0] conv_green_mask;
	logic [MASK_W-1:0] conv_blue_mask;
	logic [10:0]       conv_width;
	logic [10:0]       conv_height;
	int unsigned       column_pos;
	int unsigned       row_pos;

	logic [PIXEL_W-1:0] pending_pixels[$];
	pixel_result_t      expected_pixels[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	int  squeeze_req = 0;
	int  squeeze_done = 0;
	int  squeeze_left = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [4:0] lowest_one(input logic [MASK_W-1:0] m);
		for (int i = 0; i < MASK_W; i++) begin
			if (m[i]) begin
				return 5'(i);
			end
		end
		return 5'd16;
	endfunction

	function automatic int ones_run(input logic [MASK_W-1:0] m);
		logic [MASK_W-1:0] s;
		int n;
		n = 0;
		if (m == '0) begin
			return 0;
		end
		s = m >> lowest_one(m);
		while (s[0]) begin
			n++;
			s = s >> 1;
		end
		return n;
	endfunction

	function automatic logic [31:0] mask_field(input logic [15:0] p, input logic [MASK_W-1:0] m);
		if (m == '0) begin
			return '0;
		end
		return 32'((p & m) >> lowest_one(m));
	endfunction

	function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned lim);
		if (v == '0) begin
			return 1;
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

	// Converts one accepted pixel and advances the image position.
	function automatic pixel_result_t convert_pixel(input logic [PIXEL_W-1:0] px);
		pixel_result_t res;
		int unsigned w, h, idx, gs;
		logic [31:0] r, g, b, rgb;
		bit end_row, end_img;
		w = clamp_dim(conv_width, MAX_W);
		h = clamp_dim(conv_height, MAX_H);
		if (conv_mode == MODE_MASKED16) begin
			r = mask_field(px[15:0], conv_red_mask);
			g = mask_field(px[15:0], conv_green_mask);
			b = mask_field(px[15:0], conv_blue_mask);
			gs = (ones_run(conv_green_mask) == 6) ? 5 : 6;
			rgb = r | (g << gs) | (b << 11);
			res.alpha = '0;
		end else begin
			b = 32'(px[7:0] >> 3);
			g = 32'(px[15:8] >> 2);
			r = 32'(px[23:16] >> 3);
			rgb = r | (g << 5) | (b << 11);
			res.alpha = px[31:24];
		end
		res.color = rgb[15:0];
		idx = (h - 1 - row_pos) * w + column_pos;
		res.pixel_index = idx[INDEX_W-1:0];
		end_row = (column_pos + 1 >= w);
		end_img = end_row && (row_pos + 1 >= h);
		res.last = end_img;
		if (end_row) begin
			column_pos = 0;
			row_pos = end_img ? 0 : row_pos + 1;
		end else begin
			column_pos++;
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [10:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 11'($urandom_range(1, 6));
		end
		if (r < 80) begin
			return 11'd0;
		end
		if (r < 88) begin
			return 11'($urandom_range(7, 40));
		end
		if (r < 94) begin
			return 11'd1024;
		end
		return 11'($urandom_range(1025, 2047));
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		int r, lo, len;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			lo = $urandom_range(0, 15);
			len = $urandom_range(1, 16 - lo);
			return 16'(((32'd1 << len) - 1) << lo);
		end
		if (r == 5) begin
			return 16'h0000;
		end
		if (r == 6) begin
			return 16'hFFFF;
		end
		return 16'($urandom());
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 32'h0000_0000;
		end
		if (r == 1) begin
			return 32'hFFFF_FFFF;
		end
		return $urandom();
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PIXEL_MODE:   conv_mode = pixel_mode_t'(val[0]);
			REG_RED_MASK:     conv_red_mask = val[15:0];
			REG_GREEN_MASK:   conv_green_mask = val[15:0];
			REG_BLUE_MASK:    conv_blue_mask = val[15:0];
			REG_IMAGE_WIDTH: begin
				conv_width = val[10:0];
				column_pos = 0;
				row_pos = 0;
			end
			REG_IMAGE_HEIGHT: begin
				conv_height = val[10:0];
				column_pos = 0;
				row_pos = 0;
			end
			default: ;
		endcase
	endtask

	// Waits until every queued pixel has gone in and every result come out.
	task automatic settle_pipeline();
		while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Sender: offers queued pixels and predicts the result of each one taken.
	always @(posedge clk) begin
		logic taken;
		taken = in_valid && !in_stall;
		if (taken) begin
			expected_pixels.push_back(convert_pixel(source_pixel));
		end
		if (!in_valid || taken) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_pixels.size() != 0) begin
				source_pixel <= pending_pixels.pop_front();
				in_valid <= 1'b1;
				tx_gap <= tx_idle_on ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, including the long hold-off that fills the pipeline.
	always @(posedge clk) begin
		if (squeeze_left > 0) begin
			squeeze_left <= squeeze_left - 1;
			out_stall <= 1'b1;
		end else if (squeeze_done != squeeze_req) begin
			squeeze_done <= squeeze_done + 1;
			squeeze_left <= SQUEEZE_CYCLES;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			rx_gap <= rx_idle_on ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		pixel_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("result item with none expected: pixel_index %0d", pixel_index);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_index !== want.pixel_index) begin
					$error("pixel_index: expected %0d, got %0d", want.pixel_index, pixel_index);
					mismatches++;
				end
				if (color !== want.color) begin
					$error("color: expected %h, got %h", want.color, color);
					mismatches++;
				end
				if (alpha !== want.alpha) begin
					$error("alpha: expected %h, got %h", want.alpha, alpha);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_bmp_pixel_to_rgb565_top: done, errors");
			$finish;
		end
	end

	initial begin
		int sent, phase, n, area;
		logic [MASK_W-1:0] gm;
		conv_mode = MODE_MASKED16;
		conv_red_mask = RED_MASK_RST;
		conv_green_mask = GREEN_MASK_RST;
		conv_blue_mask = BLUE_MASK_RST;
		conv_width = 11'd1;
		conv_height = 11'd1;
		column_pos = 0;
		row_pos = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 5-5-5 masks on a one-pixel image, so every item is last.
		pending_pixels = '{32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF,
			32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F};
		settle_pipeline();

		// Byte mode on a 3 by 2 image; the seventh item opens a new image.
		write_reg(REG_PIXEL_MODE, 32'(MODE_BGRA32));
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		pending_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'h0703_0707,
			32'hFF00_00FF, 32'h00FF_FF00, 32'hAA55_AA55};
		settle_pipeline();

		// 5-6-5 masks, with zero geometry read as one by one.
		write_reg(REG_PIXEL_MODE, 32'(MODE_MASKED16));
		write_reg(REG_RED_MASK, 32'h0000_F800);
		write_reg(REG_GREEN_MASK, 32'h0000_07E0);
		write_reg(REG_BLUE_MASK, 32'h0000_001F);
		write_reg(REG_IMAGE_WIDTH, 32'd0);
		write_reg(REG_IMAGE_HEIGHT, 32'd0);
		pending_pixels = '{32'hFFFF_FFFF, 32'h0000_F800, 32'h0000_07E0};
		settle_pipeline();

		// Empty red and green masks, oversized geometry clamped to the maximum.
		write_reg(REG_RED_MASK, 32'h0000_0000);
		write_reg(REG_GREEN_MASK, 32'h0000_0000);
		write_reg(REG_BLUE_MASK, 32'h0000_FFFF);
		write_reg(REG_IMAGE_WIDTH, 32'd2047);
		write_reg(REG_IMAGE_HEIGHT, 32'd2047);
		pending_pixels = '{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h1234_0001};
		settle_pipeline();

		// Geometry rewritten part way through the image; green mask has a hole.
		write_reg(REG_RED_MASK, 32'h0000_FFFF);
		write_reg(REG_GREEN_MASK, 32'h0000_0BE0);
		write_reg(REG_BLUE_MASK, 32'h0000_8001);
		write_reg(REG_IMAGE_WIDTH, 32'd2);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		pending_pixels = '{32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'h0000_8001, 32'h0000_0BE0};
		settle_pipeline();

		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 6) begin
				write_reg(REG_PIXEL_MODE, 32'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 9) < 6) begin
				write_reg(REG_RED_MASK, 32'(pick_mask()));
			end
			if ($urandom_range(0, 9) < 6) begin
				gm = ($urandom_range(0, 2) == 0) ?
					16'(16'h003F << $urandom_range(0, 10)) : pick_mask();
				write_reg(REG_GREEN_MASK, 32'(gm));
			end
			if ($urandom_range(0, 9) < 6) begin
				write_reg(REG_BLUE_MASK, 32'(pick_mask()));
			end
			if ($urandom_range(0, 9) < 7) begin
				write_reg(REG_IMAGE_WIDTH, 32'(pick_dim()));
			end
			if ($urandom_range(0, 9) < 7) begin
				write_reg(REG_IMAGE_HEIGHT, 32'(pick_dim()));
			end
			area = clamp_dim(conv_width, MAX_W) * clamp_dim(conv_height, MAX_H);
			if (area <= 40) begin
				n = area * $urandom_range(1, 3);
			end else begin
				n = $urandom_range(10, 60);
			end
			// Now and then leave an image unfinished before the next phase.
			if ($urandom_range(0, 3) == 0) begin
				n += $urandom_range(1, 5);
			end
			if (phase == 3 || phase == 11) begin
				tx_idle_on = 1'b0;
				if (n < 30) begin
					n = 30;
				end
			end
			for (int i = 0; i < n; i++) begin
				pending_pixels.push_back(pick_pixel());
			end
			if (phase == 3 || phase == 11) begin
				squeeze_req++;
			end
			sent += n;
			phase++;
			settle_pipeline();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_bmp_pixel_to_rgb565_top: done, clean");
		end else begin
			$display("tb_bmp_pixel_to_rgb565_top: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/bmp565_pkg.sv
src/bmp565_cfg_regs.sv
src/bmp565_position.sv
src/bmp565_color_conv.sv
src/bmp_pixel_to_rgb565_top.sv
tb/sv/tb_bmp_pixel_to_rgb565_top.sv
